@@ src/rsb_pkg.sv @@
// Shared types and constants for the run-length sprite blitter.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package rsb_pkg;

	// Default framebuffer geometry.
	localparam int SCREEN_WIDTH_DEF  = 110;
	localparam int SCREEN_HEIGHT_DEF = 88;

	// Field widths of the channels.
	localparam int DATA_W  = 8;
	localparam int ADDR_W  = 14;
	localparam int COLOR_W = 8;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 9;

	// Signed working width of screen coordinates, and the widths of the
	// non-negative coordinates of a pixel that is drawn.
	localparam int POS_W  = 12;
	localparam int XPOS_W = 10;
	localparam int YPOS_W = 9;

	// Entries of the queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CIDX_W-1:0] {
		REG_DEST_X    = 3'd0,
		REG_DEST_Y    = 3'd1,
		REG_TRANSP    = 3'd2,
		REG_SUB_X     = 3'd3,
		REG_SUB_Y     = 3'd4,
		REG_SUB_W     = 3'd5,
		REG_SUB_H     = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_SIZE   = 3'd0,
		PH_WIDTH  = 3'd1,
		PH_HEIGHT = 3'd2,
		PH_COLOR  = 3'd3,
		PH_COUNT  = 3'd4,
		PH_TICK   = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	typedef struct packed {
		logic [8:0] dest_x;
		logic [8:0] dest_y;
		logic [8:0] transp;
		logic [7:0] sub_x;
		logic [7:0] sub_y;
		logic [7:0] sub_w;
		logic [7:0] sub_h;
	} cfg_t;

	// One classified word handed from the front to the back.
	typedef struct packed {
		logic               draw;
		logic [XPOS_W-1:0]  x;
		logic [YPOS_W-1:0]  y;
		logic [COLOR_W-1:0] color;
		logic               need_byte;
		logic               done;
		logic               err;
	} pix_cmd_t;

endpackage

`default_nettype wire

@@ src/rsb_if.sv @@
// Handshake channel interfaces of the sprite blitter: input words, result
// words and configuration writes. Depends on rsb_pkg.
`default_nettype none

interface rsb_item_if import rsb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [DATA_W-1:0] data_byte;

	modport source (output valid, mode, data_byte, input ready);
	modport sink (input valid, mode, data_byte, output ready);
endinterface

interface rsb_result_if import rsb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [ADDR_W-1:0]  address;
	logic [COLOR_W-1:0] color;
	logic               need_byte;
	logic               done_res;
	logic               order_error;

	modport source (output valid, write_enable, address, color, need_byte, done_res,
		order_error, input ready);
	modport sink (input valid, write_enable, address, color, need_byte, done_res,
		order_error, output ready);
endinterface

interface rsb_cfg_if import rsb_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CIDX_W-1:0]  index;
	logic [CDATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/rsb_front.sv @@
// Front of the sprite blitter: accepts words, runs the stream decoder and
// the raster walk, and pushes one classified word per item. Uses rsb_pkg.
`default_nettype none

module rsb_front import rsb_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rsb_item_if.sink      items,
	input  wire cfg_t     cfg,
	output logic          push_valid,
	input  wire logic     push_ready,
	output pix_cmd_t      push_data
);

	localparam logic signed [POS_W-1:0] SW_S = POS_W'(SCREEN_WIDTH);
	localparam logic signed [POS_W-1:0] SH_S = POS_W'(SCREEN_HEIGHT);

	phase_t                 ph_q, ph_d;
	logic [7:0]             sw_q, sw_d;
	logic [7:0]             sh_q, sh_d;
	logic [COLOR_W-1:0]     rc_q, rc_d;
	logic [8:0]             rr_q, rr_d;
	logic [7:0]             col_q, col_d;
	logic [7:0]             row_q, row_d;

	logic                   accept;
	logic                   sub_on;
	logic signed [POS_W-1:0] ox, oy, xi, yi, ny;
	logic [8:0]             rr_n;
	logic [8:0]             col_inc, row_inc;
	logic                   transp, outside, draw;

	assign items.ready = push_ready;
	assign push_valid  = items.valid;
	assign accept      = items.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_SIZE;
			sw_q  <= '0;
			sh_q  <= '0;
			rc_q  <= '0;
			rr_q  <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			ph_q  <= ph_d;
			sw_q  <= sw_d;
			sh_q  <= sh_d;
			rc_q  <= rc_d;
			rr_q  <= rr_d;
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	always_comb begin
		sub_on  = (cfg.sub_w != '0) && (cfg.sub_h != '0);
		ox      = {{(POS_W-9){cfg.dest_x[8]}}, cfg.dest_x}
			- (sub_on ? {{(POS_W-8){1'b0}}, cfg.sub_x} : POS_W'(0));
		oy      = {{(POS_W-9){cfg.dest_y[8]}}, cfg.dest_y}
			- (sub_on ? {{(POS_W-8){1'b0}}, cfg.sub_y} : POS_W'(0));
		xi      = ox + {{(POS_W-8){1'b0}}, col_q};
		yi      = oy + {{(POS_W-8){1'b0}}, row_q};
		rr_n    = rr_q - ((rr_q != '0) ? 9'd1 : 9'd0);
		col_inc = {1'b0, col_q} + 9'd1;
		row_inc = {1'b0, row_q} + 9'd1;
		ny      = oy + {{(POS_W-9){1'b0}}, row_inc};
		// A negative transparent color never matches an 8-bit color.
		transp  = ({1'b0, rc_q} == cfg.transp);
		outside = (col_q < cfg.sub_x)
			|| ({1'b0, col_q} >= ({1'b0, cfg.sub_x} + {1'b0, cfg.sub_w}))
			|| (row_q < cfg.sub_y)
			|| ({1'b0, row_q} >= ({1'b0, cfg.sub_y} + {1'b0, cfg.sub_h}));
		draw    = !xi[POS_W-1] && !yi[POS_W-1] && !(xi >= SW_S) && !transp
			&& !(sub_on && outside);

		ph_d  = ph_q;
		sw_d  = sw_q;
		sh_d  = sh_q;
		rc_d  = rc_q;
		rr_d  = rr_q;
		col_d = col_q;
		row_d = row_q;
		push_data = '0;

		if (!items.mode) begin
			unique case (ph_q)
				PH_SIZE, PH_DONE: begin
					ph_d = PH_WIDTH;
				end
				PH_WIDTH: begin
					sw_d = items.data_byte;
					ph_d = PH_HEIGHT;
				end
				PH_HEIGHT: begin
					sh_d  = items.data_byte;
					col_d = '0;
					row_d = '0;
					if (sw_q == '0 || items.data_byte == '0 || oy >= SH_S) begin
						ph_d = PH_DONE;
					end else begin
						ph_d = PH_COLOR;
					end
				end
				PH_COLOR: begin
					rc_d = items.data_byte;
					ph_d = PH_COUNT;
				end
				PH_COUNT: begin
					rr_d = (items.data_byte == '0) ? 9'd1 : {1'b0, items.data_byte};
					ph_d = PH_TICK;
				end
				default: begin
					push_data.err = 1'b1;
				end
			endcase
		end else if (ph_q != PH_TICK) begin
			push_data.err = 1'b1;
		end else begin
			rr_d = rr_n;
			if (draw) begin
				push_data.draw  = 1'b1;
				push_data.x     = xi[XPOS_W-1:0];
				push_data.y     = yi[YPOS_W-1:0];
				push_data.color = rc_q;
			end
			if (col_inc >= {1'b0, sw_q}) begin
				col_d = '0;
				row_d = row_inc[7:0];
				if (row_inc >= {1'b0, sh_q} || ny >= SH_S) begin
					ph_d = PH_DONE;
				end
			end else begin
				col_d = col_inc[7:0];
			end
			if (ph_d == PH_TICK && rr_n == '0) begin
				ph_d = PH_COLOR;
			end
		end

		push_data.need_byte = (ph_d != PH_TICK);
		push_data.done      = (ph_d == PH_DONE);
	end

endmodule

`default_nettype wire

@@ src/rsb_queue.sv @@
// Short queue of classified words between front and back of the sprite
// blitter. Uses rsb_pkg for the word type and the depth.
`default_nettype none

module rsb_queue import rsb_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire pix_cmd_t push_data,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output pix_cmd_t      pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	pix_cmd_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               push, pop;

	assign push_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/rsb_back.sv @@
// Back of the sprite blitter: takes classified words from the queue, forms
// the framebuffer address and holds the result word. Uses rsb_pkg.
`default_nettype none

module rsb_back import rsb_pkg::*; #(
	parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pop_valid,
	output logic          pop_ready,
	input  wire pix_cmd_t pop_data,
	rsb_result_if.source  results
);

	localparam logic [ADDR_W-1:0] SW_A = ADDR_W'(SCREEN_WIDTH);

	logic               valid_q;
	logic               we_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COLOR_W-1:0] color_q;
	logic               need_q, done_q, err_q;
	logic [ADDR_W-1:0]  addr_d;
	logic               load;

	// Only the low address bits are kept, so the product is formed modulo
	// the address range.
	assign addr_d    = ADDR_W'(pop_data.x) + ADDR_W'(ADDR_W'(pop_data.y) * SW_A);
	assign pop_ready = !valid_q || results.ready;
	assign load      = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			we_q    <= pop_data.draw;
			addr_q  <= addr_d;
			color_q <= pop_data.color;
			need_q  <= pop_data.need_byte;
			done_q  <= pop_data.done;
			err_q   <= pop_data.err;
		end
	end

	assign results.valid        = valid_q;
	assign results.write_enable = we_q;
	assign results.address      = addr_q;
	assign results.color        = color_q;
	assign results.need_byte    = need_q;
	assign results.done_res     = done_q;
	assign results.order_error  = err_q;

endmodule

`default_nettype wire

@@ src/rle_sprite_blitter.sv @@
// Run-length sprite blitter: decodes a stream of sprite bytes and pixel ticks
// into framebuffer writes. It takes one word per clock cycle while the queue
// has room; each word yields exactly one result word via the queue and the
// output register when the output side is ready. The front decodes and walks
// the raster in the accept cycle, a two-entry queue follows, and the back
// forms the address (one constant multiply and add) into the output register.
// Word order decides behavior: size, width, height, then color and count
// pairs, with one tick per pixel slot of a run. Configuration writes are
// taken in any cycle and act on the next word; they belong to idle periods.
// Depends on rsb_pkg, rsb_if, rsb_front, rsb_queue and rsb_back.
`default_nettype none

module rle_sprite_blitter import rsb_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	rsb_item_if.sink      items,
	rsb_result_if.source  results,
	rsb_cfg_if.sink       cfg
);

	cfg_t     cfg_q;
	logic     push_valid, push_ready, pop_valid, pop_ready;
	pix_cmd_t push_data, pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_x <= '0;
			cfg_q.dest_y <= '0;
			cfg_q.transp <= '1;
			cfg_q.sub_x  <= '0;
			cfg_q.sub_y  <= '0;
			cfg_q.sub_w  <= '0;
			cfg_q.sub_h  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEST_X: cfg_q.dest_x <= cfg.data;
				REG_DEST_Y: cfg_q.dest_y <= cfg.data;
				REG_TRANSP: cfg_q.transp <= cfg.data;
				REG_SUB_X:  cfg_q.sub_x  <= cfg.data[7:0];
				REG_SUB_Y:  cfg_q.sub_y  <= cfg.data[7:0];
				REG_SUB_W:  cfg_q.sub_w  <= cfg.data[7:0];
				REG_SUB_H:  cfg_q.sub_h  <= cfg.data[7:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	rsb_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	rsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	rsb_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

	// A pixel write never comes from a misordered word.
	a_write_not_error: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.write_enable |-> !results.order_error)
		else $error("write flagged as order error");

	// A finished frame always waits for stream bytes.
	a_done_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.done_res |-> results.need_byte)
		else $error("done without need_byte");

	// Words without a write carry a zero address and color.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.write_enable |->
			results.address == '0 && results.color == '0)
		else $error("nonzero payload without write");

	// A word accepted into an empty pipeline shows up once it has passed the queue and the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && !pop_valid && !results.valid
			|=> ##1 results.valid)
		else $error("result missing after accepted word");

endmodule

`default_nettype wire
